// ===== design/decimal_accumulator_machine_macros.svh =====
// Assertion macros shared by the decimal accumulator machine RTL.
`ifndef DECIMAL_ACCUMULATOR_MACHINE_MACROS_SVH
`define DECIMAL_ACCUMULATOR_MACHINE_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DAM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define DAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dam_pkg.sv =====
// Shared types and constants of the decimal accumulator machine.
`default_nettype none

package dam_pkg;

    // Commands carried by an input word.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    // Instruction opcodes (the hundreds part of a memory word).
    localparam logic [5:0] OP_READ   = 6'd33;
    localparam logic [5:0] OP_WRITE  = 6'd32;
    localparam logic [5:0] OP_LOAD   = 6'd31;
    localparam logic [5:0] OP_STORE  = 6'd30;
    localparam logic [5:0] OP_ADD    = 6'd21;
    localparam logic [5:0] OP_SUB    = 6'd20;
    localparam logic [5:0] OP_DIV    = 6'd11;
    localparam logic [5:0] OP_MUL    = 6'd10;
    localparam logic [5:0] OP_BR     = 6'd43;
    localparam logic [5:0] OP_BRNEG  = 6'd42;
    localparam logic [5:0] OP_BRPOS  = 6'd41;
    localparam logic [5:0] OP_BRZERO = 6'd40;
    localparam logic [5:0] OP_HALT   = 6'd50;

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_OUT   = 3'd1;
    localparam logic [2:0] ST_HALT  = 3'd2;
    localparam logic [2:0] ST_DIVZ  = 3'd3;
    localparam logic [2:0] ST_BADOP = 3'd4;
    localparam logic [2:0] ST_OVER  = 3'd5;
    localparam logic [2:0] ST_IDLE  = 3'd6;

    // Decimal split of an instruction word. Every legal word is below DEC_LIMIT,
    // and for those (w * DEC_RECIP) >> DEC_SHIFT equals w / DEC_BASE exactly.
    localparam logic [30:0] DEC_LIMIT = 31'd5100;
    localparam logic [12:0] DEC_RECIP = 13'd5243;
    localparam int          DEC_SHIFT = 19;
    localparam logic [12:0] DEC_BASE  = 13'd100;

    typedef enum logic [1:0] {
        ALU_ADD = 2'd0,
        ALU_SUB = 2'd1,
        ALU_MUL = 2'd2,
        ALU_DIV = 2'd3
    } t_alu_op;

    typedef struct packed {
        logic        start;
        t_alu_op     op;
        logic [31:0] a;
        logic [31:0] b;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [31:0] result;
    } t_alu_rsp;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [6:0]         load_address;
        logic signed [31:0] load_word;
        logic signed [31:0] read_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_value;
        logic               read_taken;
        logic [6:0]         prog_count;
        logic signed [31:0] acc_value;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/dam_alu.sv =====
// Shared iterative arithmetic unit: add, subtract, shift-add multiply, restoring divide.
`default_nettype none

module dam_alu (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dam_pkg::t_alu_req  i_req,
    output dam_pkg::t_alu_rsp  o_rsp
);

    typedef enum logic [6:0] {
        U_IDLE  = 7'b0000001,
        U_ADD   = 7'b0000010,
        U_ABS_A = 7'b0000100,
        U_ABS_B = 7'b0001000,
        U_ITER  = 7'b0010000,
        U_FIX   = 7'b0100000,
        U_DONE  = 7'b1000000
    } t_alu_state;

    t_alu_state       r_state;
    t_alu_state       n_state;
    dam_pkg::t_alu_op r_op;
    logic [32:0]      r_acc;
    logic [31:0]      r_sh;
    logic [31:0]      r_opnd;
    logic             r_neg;
    logic [4:0]       r_cnt;

    logic [32:0]      w_add_a;
    logic [32:0]      w_add_b;
    logic             w_sub;
    logic [32:0]      w_sum;

    // The one adder of the unit; every state but idle and done borrows it.
    always_comb begin
        w_add_a = '0;
        w_add_b = '0;
        w_sub   = 1'b0;
        case (r_state)
            U_ADD: begin
                w_add_a = {1'b0, r_acc[31:0]};
                w_add_b = {1'b0, r_opnd};
                w_sub   = (r_op == dam_pkg::ALU_SUB);
            end
            U_ABS_A: begin
                w_add_b = {1'b0, r_sh};
                w_sub   = 1'b1;
            end
            U_ABS_B: begin
                w_add_b = {1'b0, r_opnd};
                w_sub   = 1'b1;
            end
            U_ITER: begin
                w_add_b = {1'b0, r_opnd};
                if (r_op == dam_pkg::ALU_DIV) begin
                    w_add_a = {r_acc[31:0], r_sh[31]};
                    w_sub   = 1'b1;
                end else begin
                    w_add_a = r_acc;
                end
            end
            U_FIX: begin
                w_add_b = {1'b0, r_sh};
                w_sub   = r_neg;
            end
            default: begin
            end
        endcase
    end

    assign w_sum = w_add_a + (w_sub ? ~w_add_b : w_add_b) + 33'(w_sub);

    always_comb begin
        n_state = r_state;
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        dam_pkg::ALU_MUL: n_state = U_ITER;
                        dam_pkg::ALU_DIV: n_state = U_ABS_A;
                        default:          n_state = U_ADD;
                    endcase
                end
            end
            U_ADD:   n_state = U_DONE;
            U_ABS_A: n_state = U_ABS_B;
            U_ABS_B: n_state = U_ITER;
            U_ITER: begin
                if (r_cnt == '0) begin
                    n_state = (r_op == dam_pkg::ALU_DIV) ? U_FIX : U_DONE;
                end
            end
            U_FIX:   n_state = U_DONE;
            U_DONE:  n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            U_IDLE: begin
                if (i_req.start) begin
                    r_op   <= i_req.op;
                    r_cnt  <= '1;
                    r_neg  <= i_req.a[31] ^ i_req.b[31];
                    r_acc  <= (i_req.op == dam_pkg::ALU_ADD || i_req.op == dam_pkg::ALU_SUB)
                              ? {1'b0, i_req.a} : '0;
                    r_sh   <= (i_req.op == dam_pkg::ALU_MUL) ? i_req.b : i_req.a;
                    r_opnd <= (i_req.op == dam_pkg::ALU_MUL) ? i_req.a : i_req.b;
                end
            end
            U_ADD: r_acc <= w_sum;
            U_ABS_A: begin
                if (r_sh[31]) begin
                    r_sh <= w_sum[31:0];
                end
            end
            U_ABS_B: begin
                if (r_opnd[31]) begin
                    r_opnd <= w_sum[31:0];
                end
            end
            U_ITER: begin
                r_cnt <= r_cnt - 5'd1;
                if (r_op == dam_pkg::ALU_DIV) begin
                    // Restoring step: keep the difference only when it did not go negative.
                    if (!w_sum[32]) begin
                        r_acc <= w_sum;
                        r_sh  <= {r_sh[30:0], 1'b1};
                    end else begin
                        r_acc <= {r_acc[31:0], r_sh[31]};
                        r_sh  <= {r_sh[30:0], 1'b0};
                    end
                end else begin
                    if (r_sh[0]) begin
                        r_acc <= w_sum;
                    end
                    r_opnd <= {r_opnd[30:0], 1'b0};
                    r_sh   <= {1'b0, r_sh[31:1]};
                end
            end
            U_FIX: r_acc <= w_sum;
            default: begin
            end
        endcase
    end

    assign o_rsp.done   = (r_state == U_DONE);
    assign o_rsp.result = r_acc[31:0];

endmodule

`default_nettype wire

// ===== design/decimal_accumulator_machine.sv =====
// Top level of the decimal accumulator machine: memory, instruction sequencer, result register.
// A load or start word goes from idle straight to the response state, and so does an execute
// word that finds the machine stopped or its counter past the last address. An execute word
// whose memory word is negative or decodes to an opcode above 50 is refused from the fetch
// state. The other execute words pass through fetch, decode and operate; moves, branches,
// halt, a zero divisor and an unknown opcode then respond, while add, subtract, multiply and
// divide first wait on the shared arithmetic unit, whose 32-step shift-add and restoring-divide
// loop sets the long cases. The machine works on one input word at a time; the next word is
// taken as soon as the result has gone into the output register, even while that register
// still waits to be taken. The 100-word memory reads as zero after reset through one valid
// bit per word, so there is no clearing pass and the block is ready as soon as reset ends.
`default_nettype none

`include "decimal_accumulator_machine_macros.svh"

module decimal_accumulator_machine #(
    parameter int MEM_WORDS = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  dam_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output dam_pkg::t_out_item o_result
);

    localparam int AW = $clog2(MEM_WORDS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_FETCH  = 6'b000010,
        S_DECODE = 6'b000100,
        S_OPER   = 6'b001000,
        S_WAIT   = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

    // Control and architectural state.
    t_state         r_state,     n_state;
    logic           r_running,   n_running;
    logic [6:0]     r_pc,        n_pc;
    logic [31:0]    r_acc,       n_acc;
    logic           r_out_valid, n_out_valid;
    logic [MEM_WORDS-1:0] r_vld;

    // Payload.
    logic [31:0]        r_rval,   n_rval;
    logic [2:0]         r_status, n_status;
    logic [31:0]        r_outv,   n_outv;
    logic               r_taken,  n_taken;
    logic [6:0]         r_addr,   n_addr;
    logic [5:0]         r_opc,    n_opc;
    logic [12:0]        r_wlo,    n_wlo;
    dam_pkg::t_out_item r_out,    n_out;

    // Memory.
    logic [31:0]    r_mem [MEM_WORDS];
    logic [31:0]    r_rdata;
    logic           r_rd_vld;
    logic           w_we;
    logic [AW-1:0]  w_waddr;
    logic [31:0]    w_wdata;
    logic           w_re;
    logic [AW-1:0]  w_raddr;

    logic               w_in_acc;
    logic [31:0]        w_mem_word;
    logic [25:0]        w_dec_prod;
    logic [12:0]        w_addr_full;
    logic [6:0]         w_addr;
    logic               w_bad_word;
    logic               w_out_load;
    dam_pkg::t_alu_req  w_alu_req;
    dam_pkg::t_alu_rsp  w_alu_rsp;

    dam_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .o_rsp   (w_alu_rsp)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign w_in_acc = i_valid && !o_stall;

    // A word never written since reset reads as zero.
    assign w_mem_word = r_rd_vld ? r_rdata : '0;

    // Opcode by reciprocal multiply; the address then follows in the decode state from the registered opcode.
    assign w_dec_prod  = 26'(w_mem_word[12:0]) * 26'(dam_pkg::DEC_RECIP);
    assign w_bad_word  = w_mem_word[31] || (w_mem_word[30:0] >= dam_pkg::DEC_LIMIT);
    assign w_addr_full = r_wlo - 13'(r_opc) * dam_pkg::DEC_BASE;
    assign w_addr      = w_addr_full[6:0];

    assign w_out_load  = (r_state == S_RESP) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state     = r_state;
        n_running   = r_running;
        n_pc        = r_pc;
        n_acc       = r_acc;
        n_rval      = r_rval;
        n_status    = r_status;
        n_outv      = r_outv;
        n_taken     = r_taken;
        n_addr      = r_addr;
        n_opc       = r_opc;
        n_wlo       = r_wlo;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = '0;
        w_alu_req.start = 1'b0;
        w_alu_req.op    = dam_pkg::ALU_ADD;
        w_alu_req.a     = r_acc;
        w_alu_req.b     = w_mem_word;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_rval   = i_item.read_value;
                    n_status = dam_pkg::ST_OK;
                    n_outv   = '0;
                    n_taken  = 1'b0;
                    n_state  = S_RESP;
                    case (i_item.cmd)
                        dam_pkg::CMD_LOAD: begin
                            if (32'(i_item.load_address) < MEM_WORDS) begin
                                w_we    = 1'b1;
                                w_waddr = AW'(i_item.load_address);
                                w_wdata = i_item.load_word;
                            end
                        end
                        dam_pkg::CMD_START: begin
                            n_pc      = '0;
                            n_running = 1'b1;
                        end
                        dam_pkg::CMD_EXEC: begin
                            if (!r_running) begin
                                n_status = dam_pkg::ST_IDLE;
                            end else if (32'(r_pc) >= MEM_WORDS) begin
                                n_running = 1'b0;
                                n_status  = dam_pkg::ST_OVER;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = AW'(r_pc);
                                n_state = S_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                n_wlo = w_mem_word[12:0];
                n_opc = 6'(w_dec_prod >> dam_pkg::DEC_SHIFT);
                if (w_bad_word) begin
                    n_status  = dam_pkg::ST_BADOP;
                    n_running = 1'b0;
                    n_state   = S_RESP;
                end else begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_addr  = w_addr;
                w_re    = 1'b1;
                w_raddr = AW'(w_addr);
                n_state = S_OPER;
            end
            S_OPER: begin
                n_state = S_RESP;
                n_pc    = r_pc + 7'd1;
                case (r_opc)
                    dam_pkg::OP_READ: begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_addr);
                        w_wdata = r_rval;
                        n_taken = 1'b1;
                    end
                    dam_pkg::OP_WRITE: begin
                        n_outv   = w_mem_word;
                        n_status = dam_pkg::ST_OUT;
                    end
                    dam_pkg::OP_LOAD: n_acc = w_mem_word;
                    dam_pkg::OP_STORE: begin
                        w_we    = 1'b1;
                        w_waddr = AW'(r_addr);
                        w_wdata = r_acc;
                    end
                    dam_pkg::OP_ADD: begin
                        w_alu_req.start = 1'b1;
                        w_alu_req.op    = dam_pkg::ALU_ADD;
                        n_state         = S_WAIT;
                    end
                    dam_pkg::OP_SUB: begin
                        w_alu_req.start = 1'b1;
                        w_alu_req.op    = dam_pkg::ALU_SUB;
                        n_state         = S_WAIT;
                    end
                    dam_pkg::OP_MUL: begin
                        w_alu_req.start = 1'b1;
                        w_alu_req.op    = dam_pkg::ALU_MUL;
                        n_state         = S_WAIT;
                    end
                    dam_pkg::OP_DIV: begin
                        if (w_mem_word == '0) begin
                            n_status  = dam_pkg::ST_DIVZ;
                            n_pc      = r_pc;
                            n_running = 1'b0;
                        end else begin
                            w_alu_req.start = 1'b1;
                            w_alu_req.op    = dam_pkg::ALU_DIV;
                            n_state         = S_WAIT;
                        end
                    end
                    dam_pkg::OP_BR: n_pc = r_addr;
                    dam_pkg::OP_BRNEG: begin
                        if (r_acc[31]) begin
                            n_pc = r_addr;
                        end
                    end
                    dam_pkg::OP_BRPOS: begin
                        if (r_acc != '0 && !r_acc[31]) begin
                            n_pc = r_addr;
                        end
                    end
                    dam_pkg::OP_BRZERO: begin
                        if (r_acc == '0) begin
                            n_pc = r_addr;
                        end
                    end
                    dam_pkg::OP_HALT: begin
                        n_acc     = '0;
                        n_status  = dam_pkg::ST_HALT;
                        n_pc      = r_pc;
                        n_running = 1'b0;
                    end
                    default: begin
                        n_status  = dam_pkg::ST_BADOP;
                        n_pc      = r_pc;
                        n_running = 1'b0;
                    end
                endcase
            end
            S_WAIT: begin
                if (w_alu_rsp.done) begin
                    n_acc   = w_alu_rsp.result;
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (w_out_load) begin
            n_out.status     = r_status;
            n_out.out_value  = r_outv;
            n_out.read_taken = r_taken;
            n_out.prog_count = r_pc;
            n_out.acc_value  = r_acc;
            n_out_valid      = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_running   <= 1'b0;
            r_pc        <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_pc        <= n_pc;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rval   <= n_rval;
        r_status <= n_status;
        r_outv   <= n_outv;
        r_taken  <= n_taken;
        r_addr   <= n_addr;
        r_opc    <= n_opc;
        r_wlo    <= n_wlo;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata  <= r_mem[w_raddr];
            r_rd_vld <= r_vld[w_raddr];
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `DAM_ASSERT_SAME(a_alu_start_oper, w_alu_req.start, r_state == S_OPER, "unit started outside execute")
    `DAM_ASSERT_SAME(a_alu_done_wait, w_alu_rsp.done, r_state == S_WAIT, "unit finished while not awaited")
    `DAM_ASSERT_SAME(a_mem_we_state, w_we, r_state == S_IDLE || r_state == S_OPER, "stray memory write")
    `DAM_ASSERT_SAME(a_pc_range, 1'b1, 32'(r_pc) <= MEM_WORDS, "program counter beyond overrun value")
    `DAM_ASSERT_NEXT(a_halt_stops, r_state == S_OPER && r_opc == dam_pkg::OP_HALT, !r_running, "halt left the machine running")

endmodule

`default_nettype wire
